// ===== rtl/core/i2c_master_byte_sequencer_macros.svh =====
// Assertion macros for the I2C master byte sequencer.
`ifndef I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define I2CMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Consequent must hold on the edge after the antecedent.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CMS_ASSERT(label, prop, msg)
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/i2cms_pkg.sv =====
// Shared types and constants of the I2C master byte sequencer.
`timescale 1ns / 1ps
package i2cms_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_POLL    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT = 2'd2;

    localparam logic [15:0] HALF_BIT_RESET    = 16'd4;
    localparam logic [15:0] ACK_POLL_RESET    = 16'd10;
    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd250;

    // Command codes
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_START    = 3'd1;
    localparam logic [2:0] ACT_STOP     = 3'd2;
    localparam logic [2:0] ACT_WRITE    = 3'd3;
    localparam logic [2:0] ACT_READ     = 3'd4;
    localparam logic [2:0] ACT_WAIT_ACK = 3'd5;

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [15:0] ack_poll_ticks;
        logic [7:0]  ack_retry_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_level;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_value;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_failed;
    } t_result;

endpackage

// ===== rtl/core/i2cms_in_if.sv =====
// Input item channel: command and sampled SDA for one tick.
`timescale 1ns / 1ps
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_level;

    modport source (output valid, action, write_data, send_ack, sda_level, input ready);
    modport sink (input valid, action, write_data, send_ack, sda_level, output ready);
endinterface

// ===== rtl/core/i2cms_out_if.sv =====
// Result item channel: bus pins and status after one tick.
`timescale 1ns / 1ps
interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_value;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;

    modport source (output valid, scl_level, sda_value, sda_drive, busy_res, done_res,
                    read_data, ack_failed, input ready);
    modport sink (input valid, scl_level, sda_value, sda_drive, busy_res, done_res,
                  read_data, ack_failed, output ready);
endinterface

// ===== rtl/core/i2cms_cfg_if.sv =====
// Configuration write channel: register index and data.
`timescale 1ns / 1ps
interface i2cms_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [i2cms_pkg::CFG_INDEX_W-1:0] index;
    logic [i2cms_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/i2c_master_byte_sequencer.sv =====
// Top level of the I2C master byte sequencer: channels, result register, checks.
`timescale 1ns / 1ps
// Each input item is one bus timing tick and carries an optional command (start, stop,
// write byte, read byte with ACK/NACK, wait for ACK) plus the sampled SDA level; each
// accepted item yields exactly one result item with SCL, SDA value, SDA drive enable,
// busy, a one-tick done pulse, the last read byte and the ack failure flag. An item is
// accepted in every cycle unless the output stalls; its result appears in the output
// register on the next cycle. Input ready drops only while that register holds a result
// not yet taken. Commands given while busy are ignored. Bus phases last half_bit_ticks
// ticks, ACK polls ack_poll_ticks ticks; the tick counter width is TICK_COUNT_WIDTH.
`include "i2c_master_byte_sequencer_macros.svh"
module i2c_master_byte_sequencer #(
    parameter int TICK_COUNT_WIDTH = i2cms_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cms_in_if.sink    i_in,
    i2cms_cfg_if.sink   i_cfg,
    i2cms_out_if.source o_out
);

    i2cms_pkg::t_cfg    cfg;
    i2cms_pkg::t_item   item;
    i2cms_pkg::t_result n_out;
    i2cms_pkg::t_result r_out;
    logic               r_out_valid;
    logic               in_acc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        item.action     = i_in.action;
        item.write_data = i_in.write_data;
        item.send_ack   = i_in.send_ack;
        item.sda_level  = i_in.sda_level;
    end

    i2cms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    i2cms_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_acc),
        .i_cfg    (cfg),
        .i_item   (item),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload follows the accepted item, holds otherwise
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.scl_level  = r_out.scl_level;
    assign o_out.sda_value  = r_out.sda_value;
    assign o_out.sda_drive  = r_out.sda_drive;
    assign o_out.busy_res   = r_out.busy_res;
    assign o_out.done_res   = r_out.done_res;
    assign o_out.read_data  = r_out.read_data;
    assign o_out.ack_failed = r_out.ack_failed;

    `I2CMS_ASSERT_NEXT(a_result_follows, in_acc, r_out_valid, "accepted item gave no result")
    `I2CMS_ASSERT_NEXT(a_stall_holds, r_out_valid && !o_out.ready, r_out_valid && $stable(r_out), "stalled result changed")
    `I2CMS_ASSERT(a_done_idle, r_out_valid && r_out.done_res |-> !r_out.busy_res, "done while busy")

endmodule

// ===== rtl/core/i2cms_cfg_regs.sv =====
// Configuration registers of the I2C master byte sequencer.
`timescale 1ns / 1ps
module i2cms_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cms_cfg_if.sink          i_cfg,
    output i2cms_pkg::t_cfg    o_cfg
);

    i2cms_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks  <= i2cms_pkg::HALF_BIT_RESET;
            r_cfg.ack_poll_ticks  <= i2cms_pkg::ACK_POLL_RESET;
            r_cfg.ack_retry_limit <= i2cms_pkg::RETRY_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                i2cms_pkg::REG_HALF_BIT:    r_cfg.half_bit_ticks  <= i_cfg.data;
                i2cms_pkg::REG_ACK_POLL:    r_cfg.ack_poll_ticks  <= i_cfg.data;
                i2cms_pkg::REG_RETRY_LIMIT: r_cfg.ack_retry_limit <= i_cfg.data[7:0];
                default: ; // drop writes to unused indexes
            endcase
        end
    end

endmodule

// ===== rtl/core/i2cms_core.sv =====
// Bus phase sequencer: state registers and next-state logic for one tick.
`timescale 1ns / 1ps
module i2cms_core #(
    parameter int TICK_COUNT_WIDTH = i2cms_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cms_pkg::t_cfg     i_cfg,
    input  i2cms_pkg::t_item    i_item,
    output i2cms_pkg::t_result  o_result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C,
        PH_WR_SET, PH_WR_HI, PH_WR_LO, PH_RD_HI, PH_RD_LO,
        PH_AK_SET, PH_AK_HI, PH_WA_REL, PH_WA_POLL
    } t_phase;

    localparam logic [31:0] TickMax = (TICK_COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                      ((32'd1 << TICK_COUNT_WIDTH) - 32'd1);

    // Zero becomes one tick, values past the counter range saturate
    function automatic logic [TICK_COUNT_WIDTH-1:0] clamp_delay(input logic [15:0] d);
        logic [31:0] d32;
        d32 = {16'd0, d};
        if (d32 == 32'd0) d32 = 32'd1;
        if (d32 > TickMax) d32 = TickMax;
        return d32[TICK_COUNT_WIDTH-1:0];
    endfunction

    t_phase                      r_phase, n_phase;
    logic [TICK_COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [2:0]                  r_bit, n_bit;
    logic [7:0]                  r_shift, n_shift;
    logic [7:0]                  r_poll, n_poll;
    logic                        r_ack_choice, n_ack_choice;
    logic                        r_fail, n_fail;
    logic                        r_scl, n_scl;
    logic                        r_sda, n_sda;
    logic                        r_sda_en, n_sda_en;
    logic [7:0]                  r_read, n_read;
    logic                        n_done;
    logic [TICK_COUNT_WIDTH-1:0] d_half, d_poll;

    assign d_half = clamp_delay(i_cfg.half_bit_ticks);
    assign d_poll = clamp_delay(i_cfg.ack_poll_ticks);

    always_comb begin
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_fail       = r_fail;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_sda_en     = r_sda_en;
        n_read       = r_read;
        n_done       = 1'b0;

        if (r_phase == PH_IDLE) begin
            unique case (i_item.action)
                i2cms_pkg::ACT_START: begin
                    n_bit = 3'd0; n_sda_en = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                    n_phase = PH_ST_A; n_tick = d_half;
                end
                i2cms_pkg::ACT_STOP: begin
                    n_bit = 3'd0; n_sda_en = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                    n_phase = PH_SP_A; n_tick = d_half;
                end
                i2cms_pkg::ACT_WRITE: begin
                    n_bit = 3'd0; n_shift = i_item.write_data;
                    n_scl = 1'b0; n_sda_en = 1'b1; n_sda = i_item.write_data[7];
                    n_phase = PH_WR_SET; n_tick = d_half;
                end
                i2cms_pkg::ACT_READ: begin
                    n_bit = 3'd0; n_shift = 8'd0; n_ack_choice = i_item.send_ack;
                    n_sda_en = 1'b0; n_scl = 1'b1;
                    n_phase = PH_RD_HI; n_tick = d_half;
                end
                i2cms_pkg::ACT_WAIT_ACK: begin
                    n_bit = 3'd0; n_fail = 1'b0; n_poll = 8'd0;
                    n_sda = 1'b1; n_sda_en = 1'b0;
                    n_phase = PH_WA_REL; n_tick = d_half;
                end
                default: ; // no command, or an unused code
            endcase
        end else begin
            n_tick = r_tick - TICK_COUNT_WIDTH'(1);
            if (n_tick == '0) begin
                unique case (r_phase)
                    PH_ST_A: begin n_sda = 1'b0; n_phase = PH_ST_B; n_tick = d_half; end
                    PH_ST_B: begin n_scl = 1'b0; n_done = 1'b1; end
                    PH_SP_A: begin n_scl = 1'b1; n_phase = PH_SP_B; n_tick = d_half; end
                    PH_SP_B: begin n_sda = 1'b1; n_phase = PH_SP_C; n_tick = d_half; end
                    PH_SP_C: n_done = 1'b1;
                    PH_WR_SET: begin n_scl = 1'b1; n_phase = PH_WR_HI; n_tick = d_half; end
                    PH_WR_HI: begin n_scl = 1'b0; n_phase = PH_WR_LO; n_tick = d_half; end
                    PH_WR_LO: begin
                        if (r_bit == 3'd7) begin
                            n_sda  = 1'b1;
                            n_done = 1'b1;
                        end else begin
                            // next bit, MSB first
                            n_bit    = r_bit + 3'd1;
                            n_scl    = 1'b0;
                            n_sda_en = 1'b1;
                            n_sda    = r_shift[~n_bit];
                            n_phase  = PH_WR_SET;
                            n_tick   = d_half;
                        end
                    end
                    PH_RD_HI: begin
                        n_shift = {r_shift[6:0], i_item.sda_level};
                        n_scl   = 1'b0;
                        n_phase = PH_RD_LO;
                        n_tick  = d_half;
                    end
                    PH_RD_LO: begin
                        if (r_bit == 3'd7) begin
                            n_sda_en = 1'b1;
                            n_scl    = 1'b0;
                            n_sda    = ~r_ack_choice;
                            n_phase  = PH_AK_SET;
                        end else begin
                            n_bit   = r_bit + 3'd1;
                            n_scl   = 1'b1;
                            n_phase = PH_RD_HI;
                        end
                        n_tick = d_half;
                    end
                    PH_AK_SET: begin n_scl = 1'b1; n_phase = PH_AK_HI; n_tick = d_half; end
                    PH_AK_HI: begin n_scl = 1'b0; n_read = r_shift; n_done = 1'b1; end
                    PH_WA_REL: begin
                        n_scl = 1'b1; n_phase = PH_WA_POLL; n_tick = d_poll;
                    end
                    PH_WA_POLL: begin
                        if (!i_item.sda_level) begin
                            n_scl  = 1'b0;
                            n_done = 1'b1;
                        end else if (r_poll >= i_cfg.ack_retry_limit) begin
                            // give up: flag failure and run the stop sequence
                            n_fail   = 1'b1;
                            n_sda_en = 1'b1;
                            n_scl    = 1'b0;
                            n_sda    = 1'b0;
                            n_phase  = PH_SP_A;
                            n_tick   = d_half;
                        end else begin
                            n_poll = r_poll + 8'd1;
                            n_tick = d_poll;
                        end
                    end
                    default: n_done = 1'b1;
                endcase
                if (n_done) begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= '0;
            r_bit        <= 3'd0;
            r_shift      <= 8'd0;
            r_poll       <= 8'd0;
            r_ack_choice <= 1'b0;
            r_fail       <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_sda_en     <= 1'b1;
            r_read       <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_poll       <= n_poll;
            r_ack_choice <= n_ack_choice;
            r_fail       <= n_fail;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_sda_en     <= n_sda_en;
            r_read       <= n_read;
        end
    end

    always_comb begin
        o_result.scl_level  = n_scl;
        o_result.sda_value  = n_sda;
        o_result.sda_drive  = n_sda_en;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = n_done;
        o_result.read_data  = n_read;
        o_result.ack_failed = n_fail;
    end

endmodule
